// ===== rtl/core/pcms_pkg.sv =====
`default_nettype none
package pcms_pkg;

  localparam int NUM_STRIPS = 512;
  localparam int GROUP_SIZE = 32;
  localparam int STRIP_W    = 9;
  localparam int POS_W      = 5;
  localparam int VALUE_W    = 12;
  localparam int SIG_W      = 13;
  localparam int CORR_W     = 14;
  localparam int RANK_W     = 5;
  localparam int CNT_W      = 6;

  localparam logic [RANK_W-1:0] RANK_RESET = 5'd14;

  // command codes carried in tuser
  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  // one pedestal-subtracted sample on its way to the back end
  typedef struct packed {
    logic [STRIP_W-1:0]      strip;
    logic signed [SIG_W-1:0] signal;
  } q_entry_t;

endpackage
`default_nettype wire

// ===== rtl/core/pedestal_common_mode_subtract.sv =====
// Pedestal and common-mode subtraction for strip readout.
// Input channel (in_*): in_tuser = 0 loads a pedestal, 1 is a raw sample;
//   in_tdata carries the strip number and the 12-bit value.
// Config channel (cfg_*): writes the common-mode rank (reset 14); always ready.
// Output channel (out_*): 32 results per group once its last strip arrives,
//   out_tlast on the 32nd.
// Front end: one item per cycle while in_tready is high; pedestal lookup
//   via the pedestal RAM, sample registered, then pushed to a two-entry queue.
// Back end: stores each sample in the group RAM, then searches for the rank
//   value candidate by candidate, each candidate a sweep through the one read
//   port of the group RAM (up to 32 candidates), then reads the group again
//   and emits the results one at a time.
// The front keeps accepting while the queue has room; when the back end is
//   busy with a group the queue fills and in_tready drops.
// A stalled receiver holds the result in the output register and the back
//   end waits; no result is lost or repeated.
// Reset (synchronous, rst_n low) empties the queue and output and sets the
//   rank to 14; pedestal and group stores keep their contents.
`default_nettype none
module pedestal_common_mode_subtract (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // strip[8:0], value[20:9]
  input  wire logic        in_tuser,   // command
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [55:0]      out_tdata,  // out_strip[8:0], signal[21:9],
                                       // corrected[35:22], common_mode[48:36]
  output logic             out_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [4:0]  cfg_data    // median_rank
);

  logic [pcms_pkg::RANK_W-1:0] rank_r;
  logic                        q_push;
  logic                        q_ready;
  pcms_pkg::q_entry_t          q_in;
  logic                        q_valid;
  logic                        q_pop;
  pcms_pkg::q_entry_t          q_out;

  // rank register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rank_r <= pcms_pkg::RANK_RESET;
    end else if (cfg_valid) begin
      rank_r <= cfg_data;
    end
  end

  pcms_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata (in_tdata),
    .in_tuser (in_tuser),
    .q_push   (q_push),
    .q_ready  (q_ready),
    .q_data   (q_in)
  );

  pcms_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_ready(q_ready),
    .push_data (q_in),
    .pop_valid (q_valid),
    .pop       (q_pop),
    .pop_data  (q_out)
  );

  pcms_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .rank      (rank_r),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_data    (q_out),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

endmodule
`default_nettype wire

// ===== rtl/core/pcms_ram.sv =====
`default_nettype none
module pcms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/pcms_front.sv =====
`default_nettype none
module pcms_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [23:0]                   in_tdata,
  input  wire logic                          in_tuser,
  output logic                               q_push,
  input  wire logic                          q_ready,
  output pcms_pkg::q_entry_t                 q_data
);

  logic                              accept;
  logic [pcms_pkg::STRIP_W-1:0]      in_strip;
  logic [pcms_pkg::VALUE_W-1:0]      in_value;
  logic [pcms_pkg::VALUE_W-1:0]      ped_rdata;
  logic                              s1_v_r;
  logic                              s1_v_nxt;
  logic [pcms_pkg::STRIP_W-1:0]      s1_strip_r;
  logic [pcms_pkg::VALUE_W-1:0]      s1_value_r;

  assign in_strip  = in_tdata[8:0];
  assign in_value  = in_tdata[20:9];
  assign in_tready = !s1_v_r || q_ready;
  assign accept    = in_tvalid && in_tready;

  // pedestal table: loads write, samples read
  pcms_ram #(
    .WIDTH(pcms_pkg::VALUE_W),
    .DEPTH(pcms_pkg::NUM_STRIPS)
  ) u_ped (
    .clk  (clk),
    .we   (accept && (in_tuser == pcms_pkg::CMD_LOAD)),
    .waddr(in_strip),
    .wdata(in_value),
    .re   (accept && (in_tuser == pcms_pkg::CMD_SAMPLE)),
    .raddr(in_strip),
    .rdata(ped_rdata)
  );

  // subtract the pedestal and hand the sample to the queue
  assign q_push        = s1_v_r && q_ready;
  assign q_data.strip  = s1_strip_r;
  assign q_data.signal = $signed({1'b0, s1_value_r}) - $signed({1'b0, ped_rdata});

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (q_push) begin
      s1_v_nxt = 1'b0;
    end
    if (accept && (in_tuser == pcms_pkg::CMD_SAMPLE)) begin
      s1_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
    end
    if (accept) begin
      s1_strip_r <= in_strip;
      s1_value_r <= in_value;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/pcms_queue.sv =====
`default_nettype none
module pcms_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  output logic                    push_ready,
  input  pcms_pkg::q_entry_t      push_data,
  output logic                    pop_valid,
  input  wire logic               pop,
  output pcms_pkg::q_entry_t      pop_data
);

  pcms_pkg::q_entry_t slot_r [2];
  logic       wr_r;
  logic       rd_r;
  logic [1:0] count_r;
  logic [1:0] count_nxt;

  assign push_ready = count_r != 2'd2;
  assign pop_valid  = count_r != 2'd0;
  assign pop_data   = slot_r[rd_r];

  // track fill level
  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= 1'b0;
      rd_r    <= 1'b0;
      count_r <= 2'd0;
    end else begin
      if (push) begin
        wr_r <= !wr_r;
      end
      if (pop) begin
        rd_r <= !rd_r;
      end
      count_r <= count_nxt;
    end
    if (push) begin
      slot_r[wr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/pcms_back.sv =====
`default_nettype none
module pcms_back (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [pcms_pkg::RANK_W-1:0]   rank,
  input  wire logic                          q_valid,
  output logic                               q_pop,
  input  pcms_pkg::q_entry_t                 q_data,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [55:0]                        out_tdata,
  output logic                               out_tlast
);

  typedef enum logic [2:0] {
    ST_POP, ST_CAND, ST_CWAIT, ST_SWEEP, ST_CHECK, ST_EMIT, ST_EWAIT
  } state_t;

  state_t                                state_r;
  logic [pcms_pkg::POS_W-1:0]            i_r;
  logic [pcms_pkg::CNT_W-1:0]            cnt_r;
  logic                                  cmp_v_r;
  logic [pcms_pkg::CNT_W-1:0]            below_r;
  logic [pcms_pkg::CNT_W-1:0]            upto_r;
  logic signed [pcms_pkg::SIG_W-1:0]     v_r;
  logic signed [pcms_pkg::SIG_W-1:0]     cm_r;
  logic [pcms_pkg::STRIP_W-1:0]          base_r;
  logic                                  out_v_r;
  logic [pcms_pkg::STRIP_W-1:0]          o_strip_r;
  logic signed [pcms_pkg::SIG_W-1:0]     o_sig_r;
  logic signed [pcms_pkg::CORR_W-1:0]    o_corr_r;
  logic signed [pcms_pkg::SIG_W-1:0]     o_cm_r;
  logic                                  o_last_r;

  logic                                  g_we;
  logic                                  g_re;
  logic [pcms_pkg::POS_W-1:0]            g_raddr;
  logic [pcms_pkg::SIG_W-1:0]            g_rdata;
  logic signed [pcms_pkg::SIG_W-1:0]     rd_s;
  logic [pcms_pkg::CNT_W-1:0]            rank_ext;

  assign rd_s     = $signed(g_rdata);
  assign rank_ext = {1'b0, rank};

  // group signal store, one entry per position
  pcms_ram #(
    .WIDTH(pcms_pkg::SIG_W),
    .DEPTH(pcms_pkg::GROUP_SIZE)
  ) u_grp (
    .clk  (clk),
    .we   (g_we),
    .waddr(q_data.strip[pcms_pkg::POS_W-1:0]),
    .wdata(q_data.signal),
    .re   (g_re),
    .raddr(g_raddr),
    .rdata(g_rdata)
  );

  // memory control per state
  always_comb begin
    q_pop   = 1'b0;
    g_we    = 1'b0;
    g_re    = 1'b0;
    g_raddr = cnt_r[pcms_pkg::POS_W-1:0];
    unique case (state_r)
      ST_POP: begin
        q_pop = q_valid;
        g_we  = q_valid;
      end
      ST_CAND: begin
        g_re    = 1'b1;
        g_raddr = i_r;
      end
      ST_SWEEP: begin
        g_re = cnt_r < pcms_pkg::CNT_W'(pcms_pkg::GROUP_SIZE);
      end
      ST_EMIT: begin
        g_re = 1'b1;
      end
      default: begin
        g_re = 1'b0;
      end
    endcase
  end

  // sequencer: store, rank search, emission
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_POP;
      out_v_r <= 1'b0;
      cmp_v_r <= 1'b0;
    end else begin
      // drop the taken result unless a new one is loaded this cycle
      if (out_v_r && out_tready && (state_r != ST_EWAIT)) begin
        out_v_r <= 1'b0;
      end
      unique case (state_r)
        ST_POP: begin
          if (q_valid && (q_data.strip[pcms_pkg::POS_W-1:0] ==
                          pcms_pkg::POS_W'(pcms_pkg::GROUP_SIZE - 1))) begin
            base_r  <= {q_data.strip[pcms_pkg::STRIP_W-1:pcms_pkg::POS_W],
                        pcms_pkg::POS_W'(0)};
            i_r     <= '0;
            state_r <= ST_CAND;
          end
        end
        ST_CAND: begin
          state_r <= ST_CWAIT;
        end
        ST_CWAIT: begin
          v_r     <= rd_s;
          cnt_r   <= '0;
          below_r <= '0;
          upto_r  <= '0;
          cmp_v_r <= 1'b0;
          state_r <= ST_SWEEP;
        end
        ST_SWEEP: begin
          if (cnt_r < pcms_pkg::CNT_W'(pcms_pkg::GROUP_SIZE)) begin
            cnt_r <= cnt_r + pcms_pkg::CNT_W'(1);
          end
          cmp_v_r <= cnt_r < pcms_pkg::CNT_W'(pcms_pkg::GROUP_SIZE);
          if (cmp_v_r) begin
            below_r <= below_r + pcms_pkg::CNT_W'(rd_s < v_r);
            upto_r  <= upto_r + pcms_pkg::CNT_W'(rd_s <= v_r);
          end
          if (cnt_r == pcms_pkg::CNT_W'(pcms_pkg::GROUP_SIZE)) begin
            state_r <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if ((below_r <= rank_ext && rank_ext < upto_r) ||
              i_r == pcms_pkg::POS_W'(pcms_pkg::GROUP_SIZE - 1)) begin
            cm_r    <= v_r;
            cnt_r   <= '0;
            state_r <= ST_EMIT;
          end else begin
            i_r     <= i_r + pcms_pkg::POS_W'(1);
            state_r <= ST_CAND;
          end
        end
        ST_EMIT: begin
          state_r <= ST_EWAIT;
        end
        ST_EWAIT: begin
          if (!out_v_r || out_tready) begin
            out_v_r   <= 1'b1;
            o_strip_r <= base_r | pcms_pkg::STRIP_W'(cnt_r[pcms_pkg::POS_W-1:0]);
            o_sig_r   <= rd_s;
            o_corr_r  <= $signed({rd_s[pcms_pkg::SIG_W-1], rd_s}) -
                         $signed({cm_r[pcms_pkg::SIG_W-1], cm_r});
            o_cm_r    <= cm_r;
            o_last_r  <= cnt_r == pcms_pkg::CNT_W'(pcms_pkg::GROUP_SIZE - 1);
            if (cnt_r == pcms_pkg::CNT_W'(pcms_pkg::GROUP_SIZE - 1)) begin
              state_r <= ST_POP;
            end else begin
              cnt_r   <= cnt_r + pcms_pkg::CNT_W'(1);
              state_r <= ST_EMIT;
            end
          end
        end
        default: begin
          state_r <= ST_POP;
        end
      endcase
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tlast  = o_last_r;
  assign out_tdata  = {7'd0, o_cm_r, o_corr_r, o_sig_r, o_strip_r};

`ifndef SYNTH
  a_counts_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CHECK) |-> (below_r <= upto_r))
    else $error("rank counts out of order");
  a_counts_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CHECK) |-> (upto_r == pcms_pkg::CNT_W'(pcms_pkg::GROUP_SIZE) ||
                               upto_r < pcms_pkg::CNT_W'(pcms_pkg::GROUP_SIZE)))
    else $error("rank count beyond group size");
  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && o_last_r) |->
    (o_strip_r[pcms_pkg::POS_W-1:0] == pcms_pkg::POS_W'(pcms_pkg::GROUP_SIZE - 1)))
    else $error("last flag on wrong strip");
`endif

endmodule
`default_nettype wire
